FILE: sv/roq_pkg.sv
// ----------------------------------------------------------------------------
// roq_pkg
// Shared codes, result layout and small arithmetic helpers for the RoQ parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package roq_pkg;

  localparam int MAX_DIMENSION_DEF = 1024;
  localparam logic [31:0] MAX_CHUNK_RESET = 32'd65536;

  // result kinds
  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_INFO   = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
  localparam logic [2:0] ERR_ALIGN     = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;

  // chunk ids
  localparam logic [15:0] ID_SIGNATURE = 16'h1084;
  localparam logic [15:0] ID_INFO      = 16'h1001;
  localparam logic [15:0] ID_MONO      = 16'h1020;
  localparam logic [15:0] ID_STEREO    = 16'h1021;
  localparam logic [31:0] FILE_SIZE    = 32'hFFFF_FFFF;

  // result payload, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] payload_size;
    logic [15:0] chunk_kind;
    logic [2:0]  error_code;
    logic [10:0] padded_height;
    logic [10:0] line_stride;
    logic [15:0] pic_height;
    logic [15:0] pic_width;
    logic [15:0] framerate;
    logic        stereo;
    logic        channel;
    logic [15:0] sample;
  } roq_result_t;

  // square-table dpcm step: low seven bits squared, sign from the top bit
  function automatic logic [15:0] sq_delta(input logic [7:0] b);
    logic [13:0] s;
    s = 14'(b[6:0]) * 14'(b[6:0]);
    return b[7] ? 16'(16'd0 - {2'b00, s}) : {2'b00, s};
  endfunction

  // smallest power of two at least v, minimum 8
  function automatic logic [16:0] pow2_at_least(input logic [15:0] v);
    logic [16:0] s;
    s = 17'd8;
    for (int k = 3; k < 16; k++) begin
      if ({1'b0, v} > (17'd1 << k)) s = 17'd1 << (k + 1);
    end
    return s;
  endfunction

endpackage

FILE: sv/roq_chunk_parser_audio_decode.sv
// ----------------------------------------------------------------------------
// roq_chunk_parser_audio_decode
// RoQ byte stream parser with file and chunk header checks, info chunk dimension checks and dpcm audio
// ----------------------------------------------------------------------------
// output: a result is registered and is on m_axis in the cycle after its byte's transaction
// throughput: one byte per cycle unless a result on m_axis is held back; the state update (32-bit byte
//   count increment and compare against the chunk size) is combinational
// reset: synchronous, clears the parser to the file header phase, the output
//   register to empty and max_chunk_size to 65536
`timescale 1ns / 1ps

module roq_chunk_parser_audio_decode
  import roq_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration: max_chunk_size
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // stream_start
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample[15:0] channel[16] stereo[17] framerate[33:18] pic_width[49:34]
  // pic_height[65:50] line_stride[76:66] padded_height[87:77]
  // error_code[90:88] chunk_kind[106:91] payload_size[138:107] zero[143:139]
  output logic [143:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser    // result_kind
);

  localparam logic [2:0] PH_FILEHDR  = 3'd0;
  localparam logic [2:0] PH_CHUNKHDR = 3'd1;
  localparam logic [2:0] PH_SKIP     = 3'd2;
  localparam logic [2:0] PH_MONO     = 3'd3;
  localparam logic [2:0] PH_STEREO   = 3'd4;
  localparam logic [2:0] PH_INFO     = 3'd5;

  localparam logic [16:0] MAX_DIM = 17'(MAX_DIMENSION);

  logic [31:0] max_chunk_size;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [63:0] header_bytes, header_bytes_next;
  logic [15:0] left_predictor, left_predictor_next;
  logic [15:0] right_predictor, right_predictor_next;
  logic        right_turn, right_turn_next;
  logic        info_seen, info_seen_next;
  logic        halted, halted_next;
  logic [15:0] width_hold, width_hold_next;

  logic        out_valid;
  logic [2:0]  out_kind;
  roq_result_t out_data;

  logic        s_fire;
  logic        res_valid;
  logic [2:0]  res_kind;
  roq_result_t res;

  // state as seen after a stream start
  logic [2:0]  st_phase;
  logic [31:0] st_count;
  logic [63:0] st_hdr;
  logic        st_halted, st_info, st_turn;

  logic [31:0] count_inc;
  logic [63:0] hdr_new;
  logic [15:0] hid, harg;
  logic [31:0] hsize;
  logic [15:0] delta;
  logic        fin;
  logic [15:0] fin_w, fin_h;
  logic [16:0] stride_full, texh_full;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

  always_comb begin
    st_phase  = s_axis_tuser ? PH_FILEHDR : parse_phase;
    st_count  = s_axis_tuser ? 32'd0 : byte_count;
    st_hdr    = s_axis_tuser ? 64'd0 : header_bytes;
    st_halted = s_axis_tuser ? 1'b0 : halted;
    st_info   = s_axis_tuser ? 1'b0 : info_seen;
    st_turn   = s_axis_tuser ? 1'b0 : right_turn;

    count_inc = st_count + 32'd1;
    hdr_new   = st_hdr | (64'(s_axis_tdata) << {st_count[2:0], 3'b000});
    hid       = hdr_new[15:0];
    hsize     = hdr_new[47:16];
    harg      = hdr_new[63:48];
    delta     = sq_delta(s_axis_tdata);

    parse_phase_next     = st_phase;
    byte_count_next      = st_count;
    header_bytes_next    = st_hdr;
    left_predictor_next  = left_predictor;
    right_predictor_next = right_predictor;
    right_turn_next      = st_turn;
    info_seen_next       = st_info;
    halted_next          = st_halted;
    width_hold_next      = width_hold;

    res_valid = 1'b0;
    res_kind  = KIND_SAMPLE;
    res       = '0;
    fin       = 1'b0;
    fin_w     = '0;
    fin_h     = '0;

    if (!st_halted) begin
      unique case (st_phase) inside
        PH_FILEHDR, PH_CHUNKHDR: begin
          header_bytes_next = hdr_new;
          byte_count_next   = count_inc;
          if (st_count[2:0] == 3'd7) begin
            byte_count_next = '0;
            if (st_phase == PH_FILEHDR) begin
              res_valid = 1'b1;
              if (hid != ID_SIGNATURE || hsize != FILE_SIZE) begin
                halted_next    = 1'b1;
                res_kind       = KIND_ERROR;
                res.error_code = ERR_SIGNATURE;
              end else begin
                parse_phase_next  = PH_CHUNKHDR;
                header_bytes_next = '0;
                res_kind          = KIND_HEADER;
                res.framerate     = harg;
              end
            end else if (hsize > max_chunk_size) begin
              halted_next    = 1'b1;
              res_valid      = 1'b1;
              res_kind       = KIND_ERROR;
              res.error_code = ERR_TOO_LARGE;
            end else if (hid == ID_MONO) begin
              left_predictor_next = harg;
              parse_phase_next    = PH_MONO;
              if (hsize == 32'd0) begin
                parse_phase_next  = PH_CHUNKHDR;
                header_bytes_next = '0;
              end
            end else if (hid == ID_STEREO) begin
              left_predictor_next  = {harg[15:8], 8'h00};
              right_predictor_next = {harg[7:0], 8'h00};
              right_turn_next      = 1'b0;
              parse_phase_next     = PH_STEREO;
              if (hsize == 32'd0) begin
                parse_phase_next  = PH_CHUNKHDR;
                header_bytes_next = '0;
              end
            end else if (hid == ID_INFO && !st_info) begin
              width_hold_next   = '0;
              header_bytes_next = {16'h0000, hdr_new[47:0]};
              parse_phase_next  = PH_INFO;
              // empty info chunk finishes with zero dimensions
              fin = (hsize == 32'd0);
            end else begin
              parse_phase_next = PH_SKIP;
              if (hsize == 32'd0) begin
                parse_phase_next  = PH_CHUNKHDR;
                header_bytes_next = '0;
              end
              res_valid        = 1'b1;
              res_kind         = KIND_OTHER;
              res.chunk_kind   = hid;
              res.payload_size = hsize;
            end
          end
        end
        PH_SKIP: begin
          byte_count_next = count_inc;
          if (count_inc == st_hdr[47:16]) begin
            parse_phase_next  = PH_CHUNKHDR;
            byte_count_next   = '0;
            header_bytes_next = '0;
          end
        end
        PH_MONO, PH_STEREO: begin
          res_valid       = 1'b1;
          res_kind        = KIND_SAMPLE;
          res.stereo      = (st_phase == PH_STEREO);
          byte_count_next = count_inc;
          if (st_phase == PH_STEREO && st_turn) begin
            right_turn_next      = 1'b0;
            right_predictor_next = right_predictor + delta;
            res.sample           = right_predictor + delta;
            res.channel          = 1'b1;
          end else begin
            right_turn_next     = (st_phase == PH_STEREO);
            left_predictor_next = left_predictor + delta;
            res.sample          = left_predictor + delta;
          end
          if (count_inc == st_hdr[47:16]) begin
            parse_phase_next  = PH_CHUNKHDR;
            byte_count_next   = '0;
            header_bytes_next = '0;
          end
        end
        PH_INFO: begin
          // width in the hold register, height in the top of the header
          if (st_count == 32'd0) width_hold_next = width_hold | {8'h00, s_axis_tdata};
          else if (st_count == 32'd1) width_hold_next = width_hold | {s_axis_tdata, 8'h00};
          else if (st_count == 32'd2)
            header_bytes_next = st_hdr | {8'h00, s_axis_tdata, 48'd0};
          else if (st_count == 32'd3)
            header_bytes_next = st_hdr | {s_axis_tdata, 56'd0};
          byte_count_next = count_inc;
          fin = (count_inc == st_hdr[47:16]);
        end
        default: begin
          parse_phase_next  = PH_CHUNKHDR;
          byte_count_next   = '0;
          header_bytes_next = '0;
        end
      endcase
    end

    fin_w       = width_hold_next;
    fin_h       = header_bytes_next[63:48];
    stride_full = pow2_at_least(fin_w);
    texh_full   = pow2_at_least(fin_h);

    if (fin) begin
      parse_phase_next  = PH_CHUNKHDR;
      byte_count_next   = '0;
      header_bytes_next = '0;
      res_valid         = 1'b1;
      if (fin_w[3:0] != 4'd0 || fin_h[3:0] != 4'd0) begin
        halted_next    = 1'b1;
        res_kind       = KIND_ERROR;
        res.error_code = ERR_ALIGN;
      end else if (fin_w < 16'd8 || {1'b0, fin_w} > MAX_DIM ||
                   fin_h < 16'd8 || {1'b0, fin_h} > MAX_DIM) begin
        halted_next    = 1'b1;
        res_kind       = KIND_ERROR;
        res.error_code = ERR_RANGE;
      end else begin
        info_seen_next    = 1'b1;
        res_kind          = KIND_INFO;
        res.pic_width     = fin_w;
        res.pic_height    = fin_h;
        res.line_stride   = stride_full[10:0];
        res.padded_height = texh_full[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_size  <= MAX_CHUNK_RESET;
      parse_phase     <= PH_FILEHDR;
      byte_count      <= '0;
      header_bytes    <= '0;
      left_predictor  <= '0;
      right_predictor <= '0;
      right_turn      <= 1'b0;
      info_seen       <= 1'b0;
      halted          <= 1'b0;
      width_hold      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) max_chunk_size <= cfg_wdata;
      if (s_fire) begin
        parse_phase     <= parse_phase_next;
        byte_count      <= byte_count_next;
        header_bytes    <= header_bytes_next;
        left_predictor  <= left_predictor_next;
        right_predictor <= right_predictor_next;
        right_turn      <= right_turn_next;
        info_seen       <= info_seen_next;
        halted          <= halted_next;
        width_hold      <= width_hold_next;
        out_valid       <= res_valid;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_kind <= res_kind;
      out_data <= res;
    end
  end

  // a halted parser produces nothing until a stream start
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    s_fire && halted && !s_axis_tuser |=> !m_axis_tvalid)
    else $error("result produced while halted");

  // an error result on the output implies the parser is halted
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> halted)
    else $error("error result without halt");

  // mono samples always carry the left channel
  a_mono_left: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_SAMPLE && !out_data.stereo |-> !out_data.channel)
    else $error("mono sample on right channel");

endmodule
